@@ design/bsrt_pkg.sv @@
// Shared types and constants for the binary sequential ratio test.
// No dependencies; bsrt_if, bsrt_ln, the top level and the checker use this package.
package bsrt_pkg;

    localparam int unsigned PERMILLE_W = 10;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned SUM_W      = 21;
    localparam int unsigned LEVEL_W    = 14;
    localparam int unsigned LN_W       = 20;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [16:0] RECIP3    = 17'd43691;  // 2^17 / 3, rounded up
    localparam logic [16:0] RECIP5    = 17'd52429;  // 2^18 / 5, rounded up
    localparam logic [9:0]  PERMILLE_FULL = 10'd1000;
    localparam logic [9:0]  P_HIGH    = 10'd999;
    localparam logic [9:0]  ERR_HIGH  = 10'd499;
    localparam int          MILLI     = 1000;

    typedef enum logic [2:0] {
        REG_P_NULL  = 3'd0,
        REG_P_ALT   = 3'd1,
        REG_ALPHA   = 3'd2,
        REG_BETA    = 3'd3,
        REG_MIN     = 3'd4,
        REG_MAX     = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        DEC_CONTINUE = 2'd0,
        DEC_ACCEPT   = 2'd1,
        DEC_REJECT   = 2'd2
    } decision_t;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Handshake between the level sequencer and the logarithm unit
    typedef struct packed {
        logic       start;
        logic [9:0] operand;
    } ln_req_t;

    typedef struct packed {
        logic            done;
        logic            busy;
        logic [LN_W-1:0] value;
    } ln_rsp_t;

endpackage

@@ design/bsrt_if.sv @@
// Item channels of the ratio test: sample in, decision result out.
// Depends on bsrt_pkg for field widths.
interface bsrt_sample_if;
    logic valid;
    logic ready;
    logic action;
    logic good_flag;
    modport source (output valid, output action, output good_flag, input ready);
    modport sink   (input valid, input action, input good_flag, output ready);
endinterface

interface bsrt_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     decision;
    logic signed [bsrt_pkg::SUM_W-1:0] log_ratio;
    logic [bsrt_pkg::COUNT_W-1:0]   samples_seen;
    logic [bsrt_pkg::COUNT_W-1:0]   good_seen;
    modport source (output valid, output decision, output log_ratio,
                    output samples_seen, output good_seen, input ready);
    modport sink   (input valid, input decision, input log_ratio,
                    input samples_seen, input good_seen, output ready);
endinterface

@@ design/bsrt_div.sv @@
// Restoring divider, one quotient bit per cycle, for the logarithm series term.
// Depends on nothing but its ports; quotient must fit in 16 bits.
module bsrt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [17:0] den,
    output logic        done,
    output logic [15:0] quot
);
    logic [17:0] rem_reg, rem_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] q_reg, q_next;
    logic [17:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [18:0] trial;

    assign trial = {rem_reg, low_reg[15]};

    // Shift in one numerator bit and subtract when it fits
    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {2'b00, num[31:16]};
            low_next = num[15:0];
            den_next = den;
            cnt_next = 5'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            low_next = {low_reg[14:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 18'(trial - {1'b0, den_reg});
                q_next   = {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[17:0];
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

@@ design/bsrt_ln.sv @@
// Q16 natural logarithm of a 10-bit operand: normalize, divide, atanh series
// on one shared multiplier. Depends on bsrt_pkg and bsrt_div.
module bsrt_ln (
    input  logic              clk,
    input  logic              rst_n,
    input  bsrt_pkg::ln_req_t req,
    output bsrt_pkg::ln_rsp_t rsp
);
    import bsrt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_T2   = 8'b0000_0100,
        S_T3   = 8'b0000_1000,
        S_T5   = 8'b0001_0000,
        S_D3   = 8'b0010_0000,
        S_D5   = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } ln_state_t;

    ln_state_t   state_reg, state_next;
    logic [3:0]  k_reg, k_next;
    logic [15:0] t_reg, t_next;
    logic [15:0] t2_reg, t2_next;
    logic [15:0] t3_reg, t3_next;
    logic [15:0] t5_reg, t5_next;
    logic [15:0] q3_reg, q3_next;
    logic [15:0] q5_reg, q5_next;
    logic [LN_W-1:0] val_reg, val_next;
    logic        done_reg, done_next;

    logic [3:0]  k_comb;
    logic [25:0] shifted;
    logic [16:0] mant;
    logic        div_start, div_done;
    logic [31:0] div_num;
    logic [17:0] div_den;
    logic [15:0] div_q;
    logic [16:0] mul_a, mul_b;
    logic [33:0] prod;
    logic [17:0] s_sum;

    // Position of the leading one
    always_comb
    begin
        k_comb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (req.operand[i])
            begin
                k_comb = 4'(i);
            end
        end
    end

    assign shifted   = {req.operand, 16'd0} >> k_comb;
    assign mant      = shifted[16:0];
    assign div_start = req.start && (state_reg == S_IDLE);
    assign div_num   = {16'(mant - ONE_Q16), 16'd0};
    assign div_den   = {1'b0, mant} + {1'b0, ONE_Q16};

    bsrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = {1'b0, t_reg};
        mul_b = {1'b0, t_reg};
        case (state_reg)
            S_T3:    mul_b = {1'b0, t2_reg};
            S_T5:    begin mul_a = {1'b0, t3_reg}; mul_b = {1'b0, t2_reg}; end
            S_D3:    begin mul_a = {1'b0, t3_reg}; mul_b = RECIP3; end
            S_D5:    begin mul_a = {1'b0, t5_reg}; mul_b = RECIP5; end
            default: ;
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign s_sum = {2'b00, t_reg} + {2'b00, q3_reg} + {2'b00, q5_reg};

    // Step through the series
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        t2_next    = t2_reg;
        t3_next    = t3_reg;
        t5_next    = t5_reg;
        q3_next    = q3_reg;
        q5_next    = q5_reg;
        val_next   = val_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    k_next     = k_comb;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_q;
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                t2_next    = prod[31:16];
                state_next = S_T3;
            end
            S_T3:
            begin
                t3_next    = prod[31:16];
                state_next = S_T5;
            end
            S_T5:
            begin
                t5_next    = prod[31:16];
                state_next = S_D3;
            end
            S_D3:
            begin
                q3_next    = prod[32:17];
                state_next = S_D5;
            end
            S_D5:
            begin
                q5_next    = prod[33:18];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                val_next   = LN_W'(k_reg) * LN_W'(LN2_Q16) + LN_W'({s_sum, 1'b0});
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        t_reg   <= t_next;
        t2_reg  <= t2_next;
        t3_reg  <= t3_next;
        t5_reg  <= t5_next;
        q3_reg  <= q3_next;
        q5_reg  <= q5_next;
        val_reg <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.busy  = (state_reg != S_IDLE);
    assign rsp.value = val_reg;
endmodule

@@ design/binary_sequential_ratio_test.sv @@
// Sequential probability ratio test on good/bad samples. An observe item is
// taken and the block accepts another in the next cycle unless the pending
// result is stalled. A clear item returns its result at once, then the block
// is not ready while it works out four log ratios: eight logarithms, each a
// start, a divide, five products on the one shared multiplier, a final sum
// and a handoff. The same pass runs once after reset.
// Register writes take effect at the next clear.
module binary_sequential_ratio_test #(
    parameter int unsigned COUNT_MAX = 65535,
    parameter int unsigned LLR_LIMIT = 1000000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsrt_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsrt_pkg::DATA_W-1:0]   pwdata,
    output logic [bsrt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    bsrt_sample_if.sink                   sample,
    bsrt_result_if.source                 result
);
    import bsrt_pkg::*;

    localparam logic [COUNT_W-1:0]        CNT_SAT = COUNT_W'(COUNT_MAX);
    localparam logic signed [SUM_W+1:0]   LIM_P   = (SUM_W+2)'(LLR_LIMIT);
    localparam logic signed [SUM_W+1:0]   LIM_N   = -(SUM_W+2)'(LLR_LIMIT);

    typedef enum logic [1:0] {
        M_CALC = 2'b01,
        M_RUN  = 2'b10
    } mode_t;

    // Configuration registers
    logic [9:0]  p_null_reg, p_alt_reg, alpha_reg, beta_reg;
    logic [15:0] min_reg, max_reg;
    logic        wr_en;
    reg_index_t  widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_null_reg <= 10'd500;
            p_alt_reg  <= 10'd700;
            alpha_reg  <= 10'd50;
            beta_reg   <= 10'd100;
            min_reg    <= 16'd1;
            max_reg    <= 16'd65535;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_P_NULL: p_null_reg <= pwdata[9:0];
                REG_P_ALT:  p_alt_reg  <= pwdata[9:0];
                REG_ALPHA:  alpha_reg  <= pwdata[9:0];
                REG_BETA:   beta_reg   <= pwdata[9:0];
                REG_MIN:    min_reg    <= pwdata[15:0];
                REG_MAX:    max_reg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (widx)
            REG_P_NULL: prdata = {22'd0, p_null_reg};
            REG_P_ALT:  prdata = {22'd0, p_alt_reg};
            REG_ALPHA:  prdata = {22'd0, alpha_reg};
            REG_BETA:   prdata = {22'd0, beta_reg};
            REG_MIN:    prdata = {16'd0, min_reg};
            REG_MAX:    prdata = {16'd0, max_reg};
            default:    prdata = '0;
        endcase
    end

    // Clamp the registers as a clear latches them
    logic [9:0]  c_p0, c_p1a, c_p1, c_a, c_b;
    logic [15:0] c_min, c_max;

    always_comb
    begin
        c_p0  = (p_null_reg == 10'd0) ? 10'd1 : ((p_null_reg > P_HIGH) ? P_HIGH : p_null_reg);
        c_p1a = (p_alt_reg == 10'd0) ? 10'd1 : ((p_alt_reg > P_HIGH) ? P_HIGH : p_alt_reg);
        c_p1  = c_p1a;
        if (c_p1a <= c_p0)
        begin
            c_p1 = (c_p0 == P_HIGH) ? P_HIGH : c_p0 + 10'd1;
        end
        c_a   = (alpha_reg == 10'd0) ? 10'd1 : ((alpha_reg > ERR_HIGH) ? ERR_HIGH : alpha_reg);
        c_b   = (beta_reg == 10'd0) ? 10'd1 : ((beta_reg > ERR_HIGH) ? ERR_HIGH : beta_reg);
        c_min = (min_reg == 16'd0) ? 16'd1 : min_reg;
        c_max = (max_reg > c_min) ? max_reg : c_min;
    end

    // Test state
    mode_t       mode_reg, mode_next;
    logic [9:0]  p0_reg, p1_reg, a_reg, b_reg;
    logic [15:0] nmin_reg, nmax_reg;
    logic [COUNT_W-1:0] obs_reg, good_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [LEVEL_W-1:0] step_up_reg, step_down_reg, acc_reg, rej_reg;
    logic [2:0]  idx_reg, idx_next;
    logic        wait_reg, wait_next;
    logic [LN_W-1:0] lnum_reg;

    // Output register
    logic        ovalid_reg;
    logic [1:0]  odec_reg;
    logic signed [SUM_W-1:0] osum_reg;
    logic [COUNT_W-1:0] oobs_reg, ogood_reg;

    logic        take;
    logic        is_clear;

    assign sample.ready = (mode_reg == M_RUN) && (!ovalid_reg || result.ready);
    assign take         = sample.valid && sample.ready;
    assign is_clear     = sample.action == ACT_CLEAR;

    // Level sequencer: operand pairs for the eight logarithms
    ln_req_t     lreq;
    ln_rsp_t     lrsp;
    logic [9:0]  opnd;

    always_comb
    begin
        case (idx_reg)
            3'd0:    opnd = p1_reg;
            3'd1:    opnd = p0_reg;
            3'd2:    opnd = 10'(PERMILLE_FULL - p1_reg);
            3'd3:    opnd = 10'(PERMILLE_FULL - p0_reg);
            3'd4:    opnd = 10'(PERMILLE_FULL - b_reg);
            3'd5:    opnd = a_reg;
            3'd6:    opnd = b_reg;
            default: opnd = 10'(PERMILLE_FULL - a_reg);
        endcase
    end

    assign lreq.start   = (mode_reg == M_CALC) && !wait_reg && !lrsp.busy;
    assign lreq.operand = opnd;

    bsrt_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    // Milli-nat ratio with a floor shift
    logic signed [LN_W:0]   ln_diff;
    logic signed [31:0]     ln_scaled;
    logic signed [LEVEL_W-1:0] ratio;

    assign ln_diff   = $signed({1'b0, lnum_reg}) - $signed({1'b0, lrsp.value});
    assign ln_scaled = 32'(ln_diff) * 32'sd1000;
    assign ratio     = LEVEL_W'(ln_scaled >>> 16);

    always_comb
    begin
        mode_next = mode_reg;
        idx_next  = idx_reg;
        wait_next = wait_reg;
        if (mode_reg == M_CALC)
        begin
            if (lreq.start)
            begin
                wait_next = 1'b1;
            end
            else if (lrsp.done)
            begin
                wait_next = 1'b0;
                idx_next  = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    mode_next = M_RUN;
                end
            end
        end
        else if (take && is_clear)
        begin
            mode_next = M_CALC;
            idx_next  = 3'd0;
            wait_next = 1'b0;
        end
    end

    // Observe arithmetic and decision
    logic [COUNT_W-1:0]       obs_new, good_new;
    logic signed [SUM_W+1:0]  sum_wide;
    logic signed [SUM_W-1:0]  sum_new;
    logic [1:0]               dec_new;

    always_comb
    begin
        obs_new  = (obs_reg < CNT_SAT) ? obs_reg + 1'b1 : obs_reg;
        good_new = (sample.good_flag && good_reg < CNT_SAT) ? good_reg + 1'b1 : good_reg;
        sum_wide = (SUM_W+2)'(sum_reg)
                 + (SUM_W+2)'(sample.good_flag ? step_up_reg : step_down_reg);
        if (sum_wide > LIM_P)
        begin
            sum_wide = LIM_P;
        end
        if (sum_wide < LIM_N)
        begin
            sum_wide = LIM_N;
        end
        sum_new = SUM_W'(sum_wide);
        if (obs_new < nmin_reg)
            dec_new = DEC_CONTINUE;
        else if (sum_new >= SUM_W'(acc_reg))
            dec_new = DEC_ACCEPT;
        else if (sum_new <= SUM_W'(rej_reg))
            dec_new = DEC_REJECT;
        else if (obs_new >= nmax_reg)
            dec_new = (sum_new >= 0) ? DEC_ACCEPT : DEC_REJECT;
        else
            dec_new = DEC_CONTINUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_CALC;
            idx_reg       <= 3'd0;
            wait_reg      <= 1'b0;
            p0_reg        <= 10'd500;
            p1_reg        <= 10'd700;
            a_reg         <= 10'd50;
            b_reg         <= 10'd100;
            nmin_reg      <= 16'd1;
            nmax_reg      <= 16'd65535;
            obs_reg       <= '0;
            good_reg      <= '0;
            sum_reg       <= '0;
            step_up_reg   <= '0;
            step_down_reg <= '0;
            acc_reg       <= '0;
            rej_reg       <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            idx_reg  <= idx_next;
            wait_reg <= wait_next;
            // Store the finished ratio
            if (mode_reg == M_CALC && lrsp.done && idx_reg[0])
            begin
                case (idx_reg[2:1])
                    2'd0:    step_up_reg   <= ratio;
                    2'd1:    step_down_reg <= ratio;
                    2'd2:    acc_reg       <= ratio;
                    default: rej_reg       <= ratio;
                endcase
            end
            if (take && is_clear)
            begin
                p0_reg   <= c_p0;
                p1_reg   <= c_p1;
                a_reg    <= c_a;
                b_reg    <= c_b;
                nmin_reg <= c_min;
                nmax_reg <= c_max;
                obs_reg  <= '0;
                good_reg <= '0;
                sum_reg  <= '0;
            end
            else if (take)
            begin
                obs_reg  <= obs_new;
                good_reg <= good_new;
                sum_reg  <= sum_new;
            end
            if (take)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Hold the numerator logarithm and the result payload
    always_ff @(posedge clk)
    begin
        if (lrsp.done && !idx_reg[0])
        begin
            lnum_reg <= lrsp.value;
        end
        if (take)
        begin
            odec_reg  <= is_clear ? DEC_CONTINUE : dec_new;
            osum_reg  <= is_clear ? '0 : sum_new;
            oobs_reg  <= is_clear ? '0 : obs_new;
            ogood_reg <= is_clear ? '0 : good_new;
        end
    end

    assign result.valid        = ovalid_reg;
    assign result.decision     = odec_reg;
    assign result.log_ratio    = osum_reg;
    assign result.samples_seen = oobs_reg;
    assign result.good_seen    = ogood_reg;
endmodule

@@ design/bsrt_checker.sv @@
// Port-level checks on the ratio test, attached to the top level by bind.
// Depends on bsrt_pkg for widths and decision codes.
module bsrt_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                in_action,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          out_decision,
    input logic signed [bsrt_pkg::SUM_W-1:0]   out_log_ratio,
    input logic [bsrt_pkg::COUNT_W-1:0]        out_samples
);
    import bsrt_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_decision)
            && $stable(out_log_ratio))
        else $error("result changed while stalled");

    // Every accepted item shows a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // A clear shows an empty test
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> out_decision == DEC_CONTINUE
            && out_log_ratio == 0 && out_samples == 0)
        else $error("clear result not empty");

    // The level pass follows a clear
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> !in_ready)
        else $error("ready during level pass");
endmodule

bind binary_sequential_ratio_test bsrt_port_checker u_bsrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .in_action     (sample.action),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_decision  (result.decision),
    .out_log_ratio (result.log_ratio),
    .out_samples   (result.samples_seen)
);

@@ bench/bsrt_checker.sv @@
// Checker for the ratio test: tracks register writes, predicts each result
// and compares it with what the block returns. Depends on bsrt_pkg, bsrt_if.
module bsrt_checker
    import bsrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    bsrt_sample_if              sample,
    bsrt_result_if              result,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        decision_t   decision;
        int          log_ratio;
        int unsigned samples_seen;
        int unsigned good_seen;
    } verdict_t;

    // Held registers
    int unsigned p_null, p_alt, alpha, beta, min_n, max_n;
    // Test state
    int unsigned obs_count, good_count, min_latched, max_latched;
    int          llr_sum, step_up, step_down, accept_level, reject_level;

    verdict_t verdicts[$];

    function automatic longint ln_q16(int unsigned v);
        int     k;
        longint m, t, t2, s;
        if (v == 0)
            return -20 * 65536;
        k = 0;
        while (k < 31 && (v >> (k + 1)) != 0)
            k++;
        m  = (longint'(v) << 16) >> k;
        t  = ((m - 65536) * 65536) / (m + 65536);
        t2 = (t * t) / 65536;
        s  = t;
        t  = (t * t2) / 65536;
        s += t / 3;
        t  = (t * t2) / 65536;
        s += t / 5;
        return longint'(k) * 45426 + 2 * s;
    endfunction

    function automatic int milli_ratio(int unsigned num, int unsigned den);
        longint x;
        x = (ln_q16(num) - ln_q16(den)) * 1000;
        if (x >= 0)
            return int'(x >>> 16);
        return -int'((-x + 65535) >>> 16);
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Latch the registers into levels and zero the counts
    task automatic recompute();
        int unsigned p0, p1, a, b;
        p0 = clamp(p_null, 1, 999);
        p1 = clamp(p_alt, 1, 999);
        a  = clamp(alpha, 1, 499);
        b  = clamp(beta, 1, 499);
        if (p1 <= p0)
            p1 = (p0 + 1 > 999) ? 999 : p0 + 1;
        step_up      = milli_ratio(p1, p0);
        step_down    = milli_ratio(1000 - p1, 1000 - p0);
        accept_level = milli_ratio(1000 - b, a);
        reject_level = milli_ratio(b, 1000 - a);
        min_latched  = min_n ? min_n : 1;
        max_latched  = max_n > min_latched ? max_n : min_latched;
        obs_count  = 0;
        good_count = 0;
        llr_sum    = 0;
    endtask

    function automatic decision_t decide();
        if (obs_count < min_latched)
            return DEC_CONTINUE;
        if (llr_sum >= accept_level)
            return DEC_ACCEPT;
        if (llr_sum <= reject_level)
            return DEC_REJECT;
        if (obs_count >= max_latched)
            return llr_sum >= 0 ? DEC_ACCEPT : DEC_REJECT;
        return DEC_CONTINUE;
    endfunction

    task automatic advance(logic act, logic good);
        verdict_t v;
        int       sum;
        if (act == ACT_CLEAR) begin
            recompute();
        end
        else begin
            if (obs_count < 65535)
                obs_count++;
            if (good && good_count < 65535)
                good_count++;
            sum = llr_sum + (good ? step_up : step_down);
            if (sum > 1000000)
                sum = 1000000;
            if (sum < -1000000)
                sum = -1000000;
            llr_sum = sum;
        end
        v.decision     = decide();
        v.log_ratio    = llr_sum;
        v.samples_seen = obs_count;
        v.good_seen    = good_count;
        verdicts.push_back(v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n) begin
            p_null = 500;
            p_alt  = 700;
            alpha  = 50;
            beta   = 100;
            min_n  = 1;
            max_n  = 65535;
            recompute();
            verdicts.delete();
            errors = 0;
        end
        else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    REG_P_NULL: p_null = pwdata[9:0];
                    REG_P_ALT:  p_alt  = pwdata[9:0];
                    REG_ALPHA:  alpha  = pwdata[9:0];
                    REG_BETA:   beta   = pwdata[9:0];
                    REG_MIN:    min_n  = pwdata[15:0];
                    REG_MAX:    max_n  = pwdata[15:0];
                    default: ;
                endcase
            end
            // Predict before comparing: a result may leave as the next item is taken
            if (sample.valid && sample.ready)
                advance(sample.action, sample.good_flag);
            if (result.valid && result.ready) begin
                if (verdicts.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected", $realtime);
                end
                else begin
                    v = verdicts.pop_front();
                    if (result.decision != v.decision) begin
                        errors++;
                        $display("%0t: decision expected %0d actual %0d",
                                 $realtime, v.decision, result.decision);
                    end
                    if (int'(result.log_ratio) != v.log_ratio) begin
                        errors++;
                        $display("%0t: log_ratio expected %0d actual %0d",
                                 $realtime, v.log_ratio, result.log_ratio);
                    end
                    if (result.samples_seen != v.samples_seen) begin
                        errors++;
                        $display("%0t: samples_seen expected %0d actual %0d",
                                 $realtime, v.samples_seen, result.samples_seen);
                    end
                    if (result.good_seen != v.good_seen) begin
                        errors++;
                        $display("%0t: good_seen expected %0d actual %0d",
                                 $realtime, v.good_seen, result.good_seen);
                    end
                end
            end
        end
        pending = verdicts.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the ratio test bench: clock, reset, register writes and samples.
// Depends on bsrt_pkg, bsrt_if, the block and bsrt_checker.
module tb_top;
    import bsrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors, pending;
    int                items = 0, clears = 0, phases = 0;
    bit                quiet = 1'b0;
    longint            cycles = 0;

    bsrt_sample_if sample ();
    bsrt_result_if result ();

    binary_sequential_ratio_test dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample(sample.sink), .result(result.source)
    );

    bsrt_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .sample(sample), .result(result), .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    // Abort on a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        result.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                result.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            result.ready = 1'b1;
        end
    end

    task automatic cfg_write(reg_index_t r, int unsigned v);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(r) << 2;
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold until every result is back and the level pass has finished
    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic send(logic act, logic good);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            sample.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        sample.valid     = 1'b1;
        sample.action    = act;
        sample.good_flag = good;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
        items++;
        if (act == ACT_CLEAR)
            clears++;
        @(negedge clk);
    endtask

    task automatic configure(int unsigned p0, int unsigned p1, int unsigned a,
                             int unsigned b, int unsigned nmin, int unsigned nmax);
        sample.valid = 1'b0;
        settle();
        cfg_write(REG_P_NULL, p0);
        cfg_write(REG_P_ALT, p1);
        cfg_write(REG_ALPHA, a);
        cfg_write(REG_BETA, b);
        cfg_write(REG_MIN, nmin);
        cfg_write(REG_MAX, nmax);
        phases++;
    endtask

    // Clear, then a stream of observations with an occasional clear
    task automatic run_phase(int n, int good_pct, int clear_per_k);
        send(ACT_CLEAR, $urandom_range(0, 1));
        repeat (n) begin
            if ($urandom_range(0, 999) < clear_per_k)
                send(ACT_CLEAR, $urandom_range(0, 1));
            else
                send(ACT_OBSERVE, $urandom_range(0, 99) < good_pct);
        end
    endtask

    initial
    begin
        int p0, p1;
        sample.valid     = 1'b0;
        sample.action    = ACT_OBSERVE;
        sample.good_flag = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        settle();

        // Directed: reset levels, then both samples and a mid-stream clear
        send(ACT_OBSERVE, 1'b1);
        send(ACT_OBSERVE, 1'b0);
        send(ACT_OBSERVE, 1'b1);
        send(ACT_CLEAR, 1'b1);
        send(ACT_OBSERVE, 1'b0);
        send(ACT_OBSERVE, 1'b0);
        // Register extremes: all low, zero min samples
        configure(0, 0, 0, 0, 0, 0);
        run_phase(8, 50, 0);
        // All high, alternative equal to null, max below min
        configure(1023, 1023, 1023, 1023, 65535, 3);
        run_phase(8, 50, 0);
        // Null at the top of its range
        configure(999, 2, 499, 1, 2, 5);
        run_phase(6, 30, 0);

        // Drive the sum into its clamp
        quiet = 1'b1;
        configure(1, 999, 1, 1, 65535, 65535);
        run_phase(300, 100, 0);
        quiet = 1'b0;

        // Random settings with random content
        while (items < 1700) begin
            p0 = $urandom_range(0, 1023);
            p1 = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                           : p0 + $urandom_range(1, 300);
            configure(p0, p1 & 10'h3FF, $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 40),
                      $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 80));
            run_phase($urandom_range(60, 200), $urandom_range(0, 100), 15);
        end

        // Final stretch with no idling
        quiet = 1'b1;
        configure(500, 700, 50, 100, 1, 200);
        run_phase(120, 60, 10);

        sample.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);

        $display("Covered %0d items (%0d clears) over %0d register settings.",
                 items, clears, phases);
        $display("Included a clamped sum, forced decisions and register extremes.");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
